/* rtl/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg - shared types and constants for the positional ordered list
// Command and status codes, payload structs and size constants.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = 5;
  localparam int ELEM_W     = 32;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_POS  = 3'd5,
    CMD_DUMP     = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [4:0]  position;
  } in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              has_element;
    logic [CNT_W-1:0]  count;
    logic [1:0]        status;
    logic              last;
  } out_t;

endpackage

/* rtl/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list - bounded ordered list with positional edits
// Inserts and deletes at head, tail or a 1-based position, and dumps the
// list head first, using one shared index unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                        | Handshake
//  ---------+------------------------------+-------------------------------
//  command  | start, busy, in_item         | transfer when start & !busy
//  result   | out_valid, out_item          | no stall
//
//  Sequence: a refused command or no-op goes straight to S_OUT; an insert
//  moves entries up in S_INS from the tail down to the target and writes
//  the value, a delete closes the gap in S_DEL, and a dump walks the list
//  in S_OUT. One entry is moved per cycle through the store's read port and
//  write port. busy is high from the cycle after a transfer until the last
//  result has been shown. Reset (rst_n low, synchronous) empties the list;
//  the entry store itself is not cleared. The receiver cannot stall results.
//
module positional_ordered_list
  import pol_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_DEL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  // entry store: one read address, one write address per cycle
  logic [DATA_WIDTH-1:0] entries_r [CAPACITY];

  state_e                state_r, state_nxt;
  logic                  dump_r, dump_nxt;      // S_OUT walks the list
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;        // shared walking index
  logic [IDX_W-1:0]      idx_r, idx_nxt;        // target index of edit
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [1:0]            status_r, status_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  // shared index unit: a step down, a step up and one compare against count
  logic [IDX_W-1:0]      ptr_dec, ptr_inc;
  logic [CNT_W:0]        ptr_plus1;
  logic                  ptr_more;              // ptr + 1 < count

  // command decode at transfer time
  logic                  accept;
  logic [CNT_W:0]        pos_ext, occ_ext;
  logic                  is_full, is_empty;
  logic [IDX_W-1:0]      pos_idx, occ_idx, tail_idx;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);

  assign ptr_dec   = ptr_r - IDX_W'(1);
  assign ptr_inc   = ptr_r + IDX_W'(1);
  assign ptr_plus1 = (CNT_W+1)'(ptr_r) + (CNT_W+1)'(1);
  assign ptr_more  = ptr_plus1 < (CNT_W+1)'(occ_r);

  assign pos_ext  = (CNT_W+1)'(in_item.position);
  assign occ_ext  = (CNT_W+1)'(occ_r);
  assign is_full  = occ_r >= CNT_W'(CAPACITY);
  assign is_empty = (occ_r == '0);
  assign pos_idx  = IDX_W'(in_item.position - 5'd1);
  assign occ_idx  = IDX_W'(occ_r);
  assign tail_idx = IDX_W'(occ_r - CNT_W'(1));

  // one read mux: ptr-1 while opening a gap, ptr+1 while closing one
  always_comb begin
    unique case (state_r)
      S_INS:   rd_addr = ptr_dec;
      S_DEL:   rd_addr = ptr_inc;
      default: rd_addr = ptr_r;
    endcase
  end
  assign rd_data = entries_r[rd_addr];

  always_comb begin
    state_nxt  = state_r;
    dump_nxt   = dump_r;
    occ_nxt    = occ_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = ptr_r;
    wr_data    = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = in_item.value[DATA_WIDTH-1:0];
          status_nxt = ST_OK;
          dump_nxt   = 1'b0;
          state_nxt  = S_OUT;
          case (in_item.cmd) inside
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
              // full is checked before the position
              if (is_full) begin
                status_nxt = ST_FULL;
              end else if (in_item.cmd == CMD_INS_POS &&
                           (in_item.position == '0 ||
                            pos_ext > occ_ext + (CNT_W+1)'(1))) begin
                status_nxt = ST_BADPOS;
              end else begin
                state_nxt = S_INS;
                ptr_nxt   = occ_idx;
                if (in_item.cmd == CMD_INS_HEAD)
                  idx_nxt = '0;
                else if (in_item.cmd == CMD_INS_TAIL)
                  idx_nxt = occ_idx;
                else
                  idx_nxt = pos_idx;
              end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else if (in_item.cmd == CMD_DEL_POS &&
                           (in_item.position == '0 || pos_ext > occ_ext)) begin
                status_nxt = ST_BADPOS;
              end else begin
                state_nxt = S_DEL;
                if (in_item.cmd == CMD_DEL_HEAD)
                  ptr_nxt = '0;
                else if (in_item.cmd == CMD_DEL_TAIL)
                  ptr_nxt = tail_idx;
                else
                  ptr_nxt = pos_idx;
              end
            end
            CMD_DUMP: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                dump_nxt = 1'b1;
                ptr_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS: begin
        // move entries up one place from the tail down to the target
        wr_en = 1'b1;
        if (ptr_r > idx_r) begin
          ptr_nxt = ptr_dec;
        end else begin
          wr_data   = val_r;
          occ_nxt   = occ_r + CNT_W'(1);
          state_nxt = S_OUT;
        end
      end

      S_DEL: begin
        // close the gap from the target towards the tail
        if (ptr_more) begin
          wr_en   = 1'b1;
          ptr_nxt = ptr_inc;
        end else begin
          occ_nxt   = occ_r - CNT_W'(1);
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (dump_r && ptr_more) begin
          ptr_nxt = ptr_inc;
        end else begin
          dump_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dump_r  <= 1'b0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dump_r  <= dump_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      entries_r[wr_addr] <= wr_data;
  end

  // results: a dump shows one entry per cycle, all else one status word
  assign out_valid            = (state_r == S_OUT);
  assign out_item.element     = dump_r ? ELEM_W'(rd_data) : '0;
  assign out_item.has_element = dump_r;
  assign out_item.count       = occ_r;
  assign out_item.status      = status_r;
  assign out_item.last        = !(dump_r && ptr_more);

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not start a command");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !busy)
    else $error("sequencer still busy after final result");

  a_dump_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.has_element) |-> (out_item.status == ST_OK))
    else $error("dump entry with non-ok status");

endmodule

/* bench/pol_checker.sv */
// ----------------------------------------------------------------------------
// pol_checker - result checker for the positional ordered list
// Watches the command and result channels, keeps a shadow copy of the list,
// predicts the results of every command transfer and compares them in order.
// ----------------------------------------------------------------------------
module pol_checker
  import pol_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_item,
  input  logic out_valid,
  input  out_t out_item,
  input  logic end_of_run,
  output int   fails,
  output int   pending
);

  localparam logic [63:0] VAL_MASK  = (64'd1 << DATA_WIDTH) - 64'd1;

  logic [ELEM_W-1:0] shadow_list [CAPACITY];
  int                shadow_len;
  out_t              due_q [$];
  bit                leftover_done;

  initial begin
    fails         = 0;
    pending       = 0;
    shadow_len    = 0;
    leftover_done = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // count is taken after the command has changed the list
  function automatic out_t make_rsp(input logic [ELEM_W-1:0] e, input logic has,
                                    input status_e st, input logic lst);
    out_t r;
    r.element     = e;
    r.has_element = has;
    r.count       = CNT_W'(shadow_len);
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  task automatic predict_cmd(input in_t c);
    status_e           st;
    int                idx;
    int                pos;
    logic [ELEM_W-1:0] v;
    st  = ST_OK;
    idx = 0;
    pos = int'(c.position);
    v   = ELEM_W'(64'(c.value) & VAL_MASK);
    case (cmd_e'(c.cmd))
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        // full is tested before the position
        if (shadow_len >= CAPACITY) st = ST_FULL;
        else if (cmd_e'(c.cmd) == CMD_INS_HEAD) idx = 0;
        else if (cmd_e'(c.cmd) == CMD_INS_TAIL) idx = shadow_len;
        else if (pos == 0 || pos > shadow_len + 1) st = ST_BADPOS;
        else idx = pos - 1;
        if (st == ST_OK) begin
          for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = v;
          shadow_len++;
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
        // empty is tested before the position
        if (shadow_len == 0) st = ST_EMPTY;
        else if (cmd_e'(c.cmd) == CMD_DEL_HEAD) idx = 0;
        else if (cmd_e'(c.cmd) == CMD_DEL_TAIL) idx = shadow_len - 1;
        else if (pos == 0 || pos > shadow_len) st = ST_BADPOS;
        else idx = pos - 1;
        if (st == ST_OK) begin
          for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      CMD_DUMP: begin
        if (shadow_len == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < shadow_len; i++)
            due_q.push_back(make_rsp(shadow_list[i], 1'b1, ST_OK, i + 1 == shadow_len));
          return;
        end
      end
      default: ;
    endcase
    due_q.push_back(make_rsp('0, 1'b0, st, 1'b1));
  endtask

  task automatic check_rsp(input out_t got);
    out_t  want;
    string diffs;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing due", got));
      return;
    end
    want  = due_q.pop_front();
    diffs = "";
    if (got.element !== want.element)
      diffs = {diffs, $sformatf(" element %h/%h", got.element, want.element)};
    if (got.has_element !== want.has_element)
      diffs = {diffs, $sformatf(" has_element %b/%b", got.has_element, want.has_element)};
    if (got.count !== want.count)
      diffs = {diffs, $sformatf(" count %0d/%0d", got.count, want.count)};
    if (got.status !== want.status)
      diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
    if (got.last !== want.last)
      diffs = {diffs, $sformatf(" last %b/%b", got.last, want.last)};
    if (diffs != "") report_mismatch({"got/exp:", diffs});
  endtask

  // expectations go in before the result check, so a result in the same
  // cycle as a transfer still lines up with the oldest one
  always @(posedge clk) begin
    if (!rst_n) begin
      due_q.delete();
      shadow_len = 0;
    end else begin
      if (start && !busy) predict_cmd(in_item);
      if (out_valid) check_rsp(out_item);
      if (end_of_run && !leftover_done) begin
        leftover_done = 1'b1;
        while (due_q.size() > 0)
          report_mismatch($sformatf("result %h never arrived", due_q.pop_front()));
      end
    end
    pending <= due_q.size();
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - testbench top for the positional ordered list
// Drives a directed run through the edge cases, then episodes of random
// commands biased to grow, shrink or churn the list, with bursty pacing.
// Checking sits in pol_checker; this module gives stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb;
  import pol_pkg::*;

  localparam int RANDOM_ITEMS  = 449;
  // longest quiet stretch: a sender gap plus a full-length shift
  localparam int STALL_LIMIT   = 1000;
  // covers the longest command, an insert at the head of a nearly full list
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} bias_e;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;
  logic end_of_run;
  int   fails;
  int   pending;
  int   quiet_cycles;
  int   fill_est;     // list length as the stimulus sees it, for shaping only
  int   burst_left;

  positional_ordered_list DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  pol_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .end_of_run(end_of_run),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: any transfer on either channel counts as progress
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_t mk(input cmd_e c, input logic [31:0] v, input logic [4:0] p);
    in_t it;
    it.cmd      = c;
    it.value    = v;
    it.position = p;
    return it;
  endfunction

  // Sender pacing: bursts of back-to-back commands, random gaps between.
  // start is only lowered when a gap really follows, so it never toggles
  // twice in one step.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Called at a falling edge. busy only moves at rising edges, so its value
  // here is what the next rising edge sees.
  task automatic issue(input in_t it);
    int p;
    pace();
    in_item <= it;
    start   <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);   // transfer taken at the rising edge just passed
    p = int'(it.position);
    case (cmd_e'(it.cmd))
      CMD_INS_HEAD, CMD_INS_TAIL: if (fill_est < CAPACITY) fill_est++;
      CMD_INS_POS:  if (fill_est < CAPACITY && p != 0 && p <= fill_est + 1) fill_est++;
      CMD_DEL_HEAD, CMD_DEL_TAIL: if (fill_est > 0) fill_est--;
      CMD_DEL_POS:  if (fill_est > 0 && p != 0 && p <= fill_est) fill_est--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [4:0] ins_pos();
    return (fill_est < CAPACITY) ? 5'($urandom_range(1, fill_est + 1))
                                 : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [4:0] del_pos();
    return (fill_est > 0) ? 5'($urandom_range(1, fill_est)) : 5'($urandom_range(0, 31));
  endfunction

  // Mostly well-formed commands with valid positions; a slice of noise with
  // any code and any position so the refusal paths and cmd 7 get hit too.
  function automatic in_t pick_cmd(input bias_e bias);
    int   r;
    in_t  it;
    r = $urandom_range(0, 99);
    it = mk(CMD_NOP, pick_value(), 5'($urandom_range(0, 31)));
    case (bias)
      BIAS_GROW: begin
        if      (r < 25) it.cmd = CMD_INS_HEAD;
        else if (r < 45) it.cmd = CMD_INS_TAIL;
        else if (r < 70) begin it.cmd = CMD_INS_POS; it.position = ins_pos(); end
        else if (r < 80) it.cmd = CMD_DUMP;
        else if (r < 85) it.cmd = CMD_DEL_HEAD;
        else if (r < 90) begin it.cmd = CMD_DEL_POS; it.position = del_pos(); end
        else if (r < 97) it.cmd = 3'($urandom_range(0, 7));
      end
      BIAS_SHRINK: begin
        if      (r < 20) it.cmd = CMD_DEL_HEAD;
        else if (r < 40) it.cmd = CMD_DEL_TAIL;
        else if (r < 65) begin it.cmd = CMD_DEL_POS; it.position = del_pos(); end
        else if (r < 75) it.cmd = CMD_DUMP;
        else if (r < 80) it.cmd = CMD_INS_TAIL;
        else if (r < 88) begin it.cmd = CMD_INS_POS; it.position = ins_pos(); end
        else if (r < 97) it.cmd = 3'($urandom_range(0, 7));
      end
      default: begin
        if      (r < 12) it.cmd = CMD_INS_HEAD;
        else if (r < 24) it.cmd = CMD_INS_TAIL;
        else if (r < 38) begin it.cmd = CMD_INS_POS; it.position = ins_pos(); end
        else if (r < 50) it.cmd = CMD_DEL_HEAD;
        else if (r < 62) it.cmd = CMD_DEL_TAIL;
        else if (r < 76) begin it.cmd = CMD_DEL_POS; it.position = del_pos(); end
        else if (r < 86) it.cmd = CMD_DUMP;
        else if (r < 97) it.cmd = 3'($urandom_range(0, 7));
      end
    endcase
    return it;
  endfunction

  initial begin
    bias_e bias;
    int    ep_left;
    start      = 1'b0;
    in_item    = '0;
    rst_n      = 1'b0;
    end_of_run = 1'b0;
    fill_est   = 0;
    burst_left = 0;
    // reset held low over rising edges, released at the falling edge after
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-list cases first, empty beating bad position
    issue(mk(CMD_DUMP,     32'h0,         5'd0));    // dump of empty list
    issue(mk(CMD_DEL_HEAD, 32'h0,         5'd0));
    issue(mk(CMD_DEL_TAIL, 32'h0,         5'd0));
    issue(mk(CMD_DEL_POS,  32'h0,         5'd0));    // empty wins over bad pos
    issue(mk(CMD_INS_POS,  32'h1234_5678, 5'd0));    // position zero
    issue(mk(CMD_INS_POS,  32'h1234_5678, 5'd2));    // beyond count+1
    issue(mk(CMD_INS_POS,  32'h0000_1111, 5'd1));
    issue(mk(CMD_INS_HEAD, 32'hFFFF_FFFF, 5'd31));
    issue(mk(CMD_INS_TAIL, 32'h0,         5'd0));
    issue(mk(CMD_INS_POS,  32'hA5A5_A5A5, 5'd4));    // count+1 appends
    issue(mk(CMD_INS_POS,  32'h5A5A_5A5A, 5'd2));    // middle
    issue(mk(CMD_INS_POS,  32'hDEAD_BEEF, 5'd31));   // far out of range
    issue(mk(CMD_DUMP,     32'h0,         5'd0));
    issue(mk(CMD_DEL_POS,  32'h0,         5'd0));
    issue(mk(CMD_DEL_POS,  32'h0,         5'd6));    // count+1 is bad for delete
    issue(mk(CMD_DEL_POS,  32'h0,         5'd5));    // tail by position
    issue(mk(CMD_DEL_POS,  32'h0,         5'd2));
    issue(mk(CMD_DEL_HEAD, 32'h0,         5'd0));
    issue(mk(CMD_DEL_TAIL, 32'h0,         5'd0));
    issue(mk(CMD_NOP,      $urandom,      5'd31));   // unused code
    issue(mk(CMD_DUMP,     32'h0,         5'd0));

    // Random episodes; growth runs drive the list into full, shrink runs to
    // empty, so refusals at both ends come up repeatedly
    ep_left = 0;
    bias    = BIAS_MIXED;
    repeat (RANDOM_ITEMS) begin
      if (ep_left == 0) begin
        ep_left = $urandom_range(10, 40);
        bias    = bias_e'($urandom_range(0, 2));
      end
      ep_left--;
      issue(pick_cmd(bias));
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(negedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
